### design/llnd_pkg.sv
// llnd_pkg: shared types and constants for the least-loaded node dispatcher.
// Holds the sequencer state enum, the per-node record type and register map.
// No dependencies.
package llnd_pkg;

   // Field widths fixed by the interface
   localparam int DATA_W      = 8;
   localparam int OUT_IDX_W   = 4;

   // Defaults for the top-level parameter and the capacity register
   localparam int             NODE_COUNT_DEF = 10;
   localparam logic [DATA_W-1:0] CAPACITY_RESET = 8'd100;

   // Configuration port: byte address, register index in bit 2 upward
   localparam int   CSR_ADDR_W        = 3;
   localparam int   CSR_DATA_W        = 32;
   localparam logic CSR_NODE_CAPACITY = 1'b0;

   // Request kinds
   localparam logic KIND_CPU = 1'b0;
   localparam logic KIND_IO  = 1'b1;

   // Saturation limit of the per-node counters
   localparam logic [DATA_W-1:0] COUNT_MAX = '1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // One node entry as held in the node table
   typedef struct packed {
      logic [DATA_W-1:0] free;
      logic [DATA_W-1:0] cpu;
      logic [DATA_W-1:0] io;
   } node_rec_type;

endpackage

### design/least_loaded_node_dispatch.sv
// least_loaded_node_dispatch: picks the active node with most free slots, or
// activates the first idle node, and updates that node's counters.
// Depends on llnd_pkg.
//
// The sequencer steps through the idle state that takes start, the scan
// state (one table read a cycle, each entry compared in the cycle after its
// read), then the decide state that picks, updates and writes back the
// chosen entry; the result strobe is registered from the decide state.
// A new request is taken only once the sequencer is back in idle.
// Reset (synchronous): all nodes inactive, capacity 100; table entries are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module least_loaded_node_dispatch #(
   parameter int NODE_COUNT = llnd_pkg::NODE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_request_kind,
   // result channel
   output logic                              rsp_valid,
   output logic                              rsp_accepted,
   output logic [llnd_pkg::OUT_IDX_W-1:0]    rsp_node_index,
   output logic                              rsp_newly_activated,
   output logic [llnd_pkg::DATA_W-1:0]       rsp_free_after,
   output logic [llnd_pkg::DATA_W-1:0]       rsp_cpu_total,
   output logic [llnd_pkg::DATA_W-1:0]       rsp_io_total,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [llnd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [llnd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [llnd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import llnd_pkg::*;

   localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int CNT_W = $clog2(NODE_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
   localparam logic [CNT_W-1:0] NODE_CNT = CNT_W'(NODE_COUNT);

   // ---------------------------------------------------------------------
   // Storage
   // ---------------------------------------------------------------------
   // node table: entries are meaningful only once the node is active
   node_rec_type              node_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0]     node_active_ff, node_active_in;
   logic [DATA_W-1:0]         capacity_ff, capacity_in;

   // sequencer
   state_type                 state_ff, state_in;
   logic                      kind_ff, kind_in;
   logic [CNT_W-1:0]          iss_idx_ff, iss_idx_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]          cmp_idx_ff;
   node_rec_type              rd_rec_ff;
   logic                      rd_act_ff;

   // scan results
   logic                      best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   node_rec_type              best_rec_ff, best_rec_in;
   logic                      inact_vld_ff, inact_vld_in;
   logic [IDX_W-1:0]          inact_idx_ff, inact_idx_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_acc_ff, rsp_acc_in;
   logic [OUT_IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic                      rsp_fresh_ff, rsp_fresh_in;
   node_rec_type              rsp_rec_ff, rsp_rec_in;

   // table port controls
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   node_rec_type              wr_rec;

   // decide-cycle selection
   logic                      take;
   logic                      fresh;
   logic [IDX_W-1:0]          sel_idx;
   node_rec_type              sel_rec;
   node_rec_type              upd_rec;

   logic                      csr_wr;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite &&
                   (paddr[CSR_ADDR_W-1:2] == CSR_NODE_CAPACITY);

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == CSR_NODE_CAPACITY) begin
         prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   assign capacity_in = csr_wr ? pwdata[DATA_W-1:0] : capacity_ff;

   // ---------------------------------------------------------------------
   // Decide cycle: pick the node and work out its updated entry
   // ---------------------------------------------------------------------
   always_comb begin
      take    = 1'b0;
      fresh   = 1'b0;
      sel_idx = best_idx_ff;
      sel_rec = best_rec_ff;
      if (best_vld_ff) begin
         take = 1'b1;
      end else if (inact_vld_ff) begin
         take         = 1'b1;
         fresh        = 1'b1;
         sel_idx      = inact_idx_ff;
         sel_rec.free = capacity_ff;
         sel_rec.cpu  = '0;
         sel_rec.io   = '0;
      end

      // decrement stops at zero, counters stop at their maximum
      upd_rec = sel_rec;
      if (sel_rec.free != '0) begin
         upd_rec.free = sel_rec.free - 1'b1;
      end
      if (kind_ff == KIND_CPU) begin
         if (sel_rec.cpu != COUNT_MAX) upd_rec.cpu = sel_rec.cpu + 1'b1;
      end else begin
         if (sel_rec.io != COUNT_MAX) upd_rec.io = sel_rec.io + 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state and datapath controls
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      iss_idx_in     = iss_idx_ff;
      cmp_vld_in     = 1'b0;
      best_vld_in    = best_vld_ff;
      best_idx_in    = best_idx_ff;
      best_rec_in    = best_rec_ff;
      inact_vld_in   = inact_vld_ff;
      inact_idx_in   = inact_idx_ff;
      node_active_in = node_active_ff;
      rsp_valid_in   = 1'b0;
      rsp_acc_in     = 1'b0;
      rsp_idx_in     = '0;
      rsp_fresh_in   = 1'b0;
      rsp_rec_in     = '0;
      rd_en          = 1'b0;
      rd_addr        = iss_idx_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = sel_idx;
      wr_rec         = upd_rec;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in     = ST_SCAN;
               kind_in      = req_request_kind;
               iss_idx_in   = '0;
               best_vld_in  = 1'b0;
               inact_vld_in = 1'b0;
            end
         end

         ST_SCAN: begin
            // issue one table read a cycle
            if (iss_idx_ff != NODE_CNT) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               iss_idx_in = iss_idx_ff + 1'b1;
            end
            // compare the entry read last cycle
            if (cmp_vld_ff) begin
               if (rd_act_ff && rd_rec_ff.free != '0 &&
                   (!best_vld_ff || rd_rec_ff.free > best_rec_ff.free)) begin
                  best_vld_in = 1'b1;
                  best_idx_in = cmp_idx_ff;
                  best_rec_in = rd_rec_ff;
               end
               if (!rd_act_ff && !inact_vld_ff) begin
                  inact_vld_in = 1'b1;
                  inact_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            state_in     = ST_IDLE;
            wr_en        = take;
            rsp_valid_in = 1'b1;
            if (take) begin
               rsp_acc_in   = 1'b1;
               rsp_idx_in   = OUT_IDX_W'(sel_idx);
               rsp_fresh_in = fresh;
               rsp_rec_in   = upd_rec;
               if (fresh) node_active_in[sel_idx] = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         capacity_ff    <= CAPACITY_RESET;
         node_active_ff <= '0;
         cmp_vld_ff     <= 1'b0;
         iss_idx_ff     <= '0;
         best_vld_ff    <= 1'b0;
         inact_vld_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         capacity_ff    <= capacity_in;
         node_active_ff <= node_active_in;
         cmp_vld_ff     <= cmp_vld_in;
         iss_idx_ff     <= iss_idx_in;
         best_vld_ff    <= best_vld_in;
         inact_vld_ff   <= inact_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      best_idx_ff  <= best_idx_in;
      best_rec_ff  <= best_rec_in;
      inact_idx_ff <= inact_idx_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   // ---------------------------------------------------------------------
   // Node table: one registered read, one write
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_rec_ff  <= node_mem[rd_addr];
         rd_act_ff  <= node_active_ff[rd_addr];
         cmp_idx_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_rec;
      end
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_node_index      = rsp_idx_ff;
   assign rsp_newly_activated = rsp_fresh_ff;
   assign rsp_free_after      = rsp_rec_ff.free;
   assign rsp_cpu_total       = rsp_rec_ff.cpu;
   assign rsp_io_total        = rsp_rec_ff.io;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a result beat only ever follows the decide cycle
   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DECIDE))
      else $error("result beat without a decide cycle");

   // a taken request always starts the scan
   a_start_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start the scan");

   // a rejected request reports all-zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |->
         (rsp_node_index == '0 && !rsp_newly_activated && rsp_free_after == '0 &&
          rsp_cpu_total == '0 && rsp_io_total == '0))
      else $error("rejected request with non-zero fields");

   // a freshly activated node has served exactly this one request
   a_fresh_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_newly_activated) |->
         (({1'b0, rsp_cpu_total} + {1'b0, rsp_io_total}) == 9'd1))
      else $error("fresh node counters do not total one");

endmodule
